// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the MD5 stream hasher.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/md5sh_pkg.sv =====
// Package of the MD5 stream hasher: sequencer states, control structs,
// initial chaining value and the round tables. Depends on nothing.
package md5sh_pkg;

    // Block buffer geometry: 16 message words of 32 bits.
    localparam int unsigned BLK_WORDS  = 16;
    localparam int unsigned WORD_BITS  = 32;

    // Initial chaining value.
    localparam logic [31:0] MD5_IV_A = 32'h6745_2301;
    localparam logic [31:0] MD5_IV_B = 32'hefcd_ab89;
    localparam logic [31:0] MD5_IV_C = 32'h98ba_dcfe;
    localparam logic [31:0] MD5_IV_D = 32'h1032_5476;

    // Padding marker byte.
    localparam logic [31:0] PAD_MARKER = 32'h0000_0080;

    // Word positions of the 64-bit length field in the last block.
    localparam logic [3:0] LEN_LO_WORD = 4'd14;
    localparam logic [3:0] LEN_HI_WORD = 4'd15;
    localparam logic [3:0] LAST_WORD   = 4'd15;
    localparam logic [5:0] LAST_ROUND  = 6'd63;
    localparam logic [1:0] LAST_DIGEST = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_DIGEST
    } md5sh_state_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic       in_ready;
        logic       load_vars;
        logic       round_en;
        logic       add_chain;
        logic       chain_init;
        logic       pad_write;
        logic       pad_first;
        logic       pad_len;
        logic [3:0] pad_ptr;
        logic [5:0] round_idx;
        logic [3:0] rd_addr;
        logic       out_valid;
        logic [1:0] word_idx;
    } md5sh_ctrl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic       in_accept;
        logic       in_last;
        logic       block_full;
        logic [3:0] start_ptr;
        logic       pend_high;
        logic       out_accept;
    } md5sh_stat_t;

    // Message word used by a round.
    function automatic logic [3:0] md5_msg_index(input logic [5:0] idx);
        logic [3:0] lo;
        logic [3:0] res;
        lo = idx[3:0];
        case (idx[5:4])
            2'd0:    res = lo;
            2'd1:    res = lo + {lo[1:0], 2'b00} + 4'd1;
            2'd2:    res = lo + {lo[2:0], 1'b0} + 4'd5;
            2'd3:    res = {lo[0], 3'b000} - lo;
            default: res = lo;
        endcase
        return res;
    endfunction

    // Rotate amount of a round.
    function automatic logic [4:0] md5_shift(input logic [5:0] idx);
        logic [4:0] res;
        case ({idx[5:4], idx[1:0]})
            4'd0:    res = 5'd7;
            4'd1:    res = 5'd12;
            4'd2:    res = 5'd17;
            4'd3:    res = 5'd22;
            4'd4:    res = 5'd5;
            4'd5:    res = 5'd9;
            4'd6:    res = 5'd14;
            4'd7:    res = 5'd20;
            4'd8:    res = 5'd4;
            4'd9:    res = 5'd11;
            4'd10:   res = 5'd16;
            4'd11:   res = 5'd23;
            4'd12:   res = 5'd6;
            4'd13:   res = 5'd10;
            4'd14:   res = 5'd15;
            4'd15:   res = 5'd21;
            default: res = 5'd7;
        endcase
        return res;
    endfunction

    // Additive round constant.
    function automatic logic [31:0] md5_k(input logic [5:0] idx);
        logic [31:0] res;
        case (idx)
            6'd0:    res = 32'hd76aa478;
            6'd1:    res = 32'he8c7b756;
            6'd2:    res = 32'h242070db;
            6'd3:    res = 32'hc1bdceee;
            6'd4:    res = 32'hf57c0faf;
            6'd5:    res = 32'h4787c62a;
            6'd6:    res = 32'ha8304613;
            6'd7:    res = 32'hfd469501;
            6'd8:    res = 32'h698098d8;
            6'd9:    res = 32'h8b44f7af;
            6'd10:   res = 32'hffff5bb1;
            6'd11:   res = 32'h895cd7be;
            6'd12:   res = 32'h6b901122;
            6'd13:   res = 32'hfd987193;
            6'd14:   res = 32'ha679438e;
            6'd15:   res = 32'h49b40821;
            6'd16:   res = 32'hf61e2562;
            6'd17:   res = 32'hc040b340;
            6'd18:   res = 32'h265e5a51;
            6'd19:   res = 32'he9b6c7aa;
            6'd20:   res = 32'hd62f105d;
            6'd21:   res = 32'h02441453;
            6'd22:   res = 32'hd8a1e681;
            6'd23:   res = 32'he7d3fbc8;
            6'd24:   res = 32'h21e1cde6;
            6'd25:   res = 32'hc33707d6;
            6'd26:   res = 32'hf4d50d87;
            6'd27:   res = 32'h455a14ed;
            6'd28:   res = 32'ha9e3e905;
            6'd29:   res = 32'hfcefa3f8;
            6'd30:   res = 32'h676f02d9;
            6'd31:   res = 32'h8d2a4c8a;
            6'd32:   res = 32'hfffa3942;
            6'd33:   res = 32'h8771f681;
            6'd34:   res = 32'h6d9d6122;
            6'd35:   res = 32'hfde5380c;
            6'd36:   res = 32'ha4beea44;
            6'd37:   res = 32'h4bdecfa9;
            6'd38:   res = 32'hf6bb4b60;
            6'd39:   res = 32'hbebfbc70;
            6'd40:   res = 32'h289b7ec6;
            6'd41:   res = 32'heaa127fa;
            6'd42:   res = 32'hd4ef3085;
            6'd43:   res = 32'h04881d05;
            6'd44:   res = 32'hd9d4d039;
            6'd45:   res = 32'he6db99e5;
            6'd46:   res = 32'h1fa27cf8;
            6'd47:   res = 32'hc4ac5665;
            6'd48:   res = 32'hf4292244;
            6'd49:   res = 32'h432aff97;
            6'd50:   res = 32'hab9423a7;
            6'd51:   res = 32'hfc93a039;
            6'd52:   res = 32'h655b59c3;
            6'd53:   res = 32'h8f0ccc92;
            6'd54:   res = 32'hffeff47d;
            6'd55:   res = 32'h85845dd1;
            6'd56:   res = 32'h6fa87e4f;
            6'd57:   res = 32'hfe2ce6e0;
            6'd58:   res = 32'ha3014314;
            6'd59:   res = 32'h4e0811a1;
            6'd60:   res = 32'hf7537e82;
            6'd61:   res = 32'hbd3af235;
            6'd62:   res = 32'h2ad7d2bb;
            6'd63:   res = 32'heb86d391;
            default: res = 32'hd76aa478;
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/md5sh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the message block buffer.
module md5sh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/md5sh_round.sv =====
// MD5 round unit: one of the 64 steps of the compression function.
// Depends on md5sh_pkg for the round constants and rotate amounts.
module md5sh_round
    import md5sh_pkg::*;
(
    input  logic [5:0]  round_idx,
    input  logic [31:0] a_in,
    input  logic [31:0] b_in,
    input  logic [31:0] c_in,
    input  logic [31:0] d_in,
    input  logic [31:0] msg_word,
    output logic [31:0] a_out,
    output logic [31:0] b_out,
    output logic [31:0] c_out,
    output logic [31:0] d_out
);

    logic [31:0] f_val;
    logic [31:0] sum;
    logic [63:0] rot_dbl;

    // Boolean function of the current quarter.
    always_comb
    begin
        case (round_idx[5:4])
            2'd0:    f_val = d_in ^ (b_in & (c_in ^ d_in));
            2'd1:    f_val = c_in ^ (d_in & (b_in ^ c_in));
            2'd2:    f_val = b_in ^ c_in ^ d_in;
            2'd3:    f_val = c_in ^ (b_in | ~d_in);
            default: f_val = b_in ^ c_in ^ d_in;
        endcase
    end

    // Sum, rotate left, and add b.
    assign sum     = a_in + f_val + md5_k(round_idx) + msg_word;
    assign rot_dbl = {sum, sum} << md5_shift(round_idx);

    assign a_out = d_in;
    assign b_out = b_in + rot_dbl[63:32];
    assign c_out = b_in;
    assign d_out = c_in;

endmodule

// ===== hw/rtl/md5sh_ctrl.sv =====
// Sequencer of the MD5 stream hasher: byte intake, padding writes, the
// 64-round loop and digest output. Depends on md5sh_pkg.
module md5sh_ctrl
    import md5sh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  md5sh_stat_t stat,
    output md5sh_ctrl_t ctrl
);

    md5sh_state_t state_reg, state_next;
    logic [5:0]   round_reg, round_next;
    logic [3:0]   ptr_reg, ptr_next;
    logic [1:0]   widx_reg, widx_next;
    logic         finish_reg, finish_next;
    logic         started_reg, started_next;
    logic         len_done_reg, len_done_next;
    logic         first_reg, first_next;
    logic         second_reg, second_next;
    logic [5:0]   round_plus;

    assign round_plus = round_reg + 6'd1;

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            round_reg    <= '0;
            ptr_reg      <= '0;
            widx_reg     <= '0;
            finish_reg   <= 1'b0;
            started_reg  <= 1'b0;
            len_done_reg <= 1'b0;
            first_reg    <= 1'b0;
            second_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            ptr_reg      <= ptr_next;
            widx_reg     <= widx_next;
            finish_reg   <= finish_next;
            started_reg  <= started_next;
            len_done_reg <= len_done_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
        end
    end

    // Next state and control outputs.
    always_comb
    begin
        state_next    = state_reg;
        round_next    = round_reg;
        ptr_next      = ptr_reg;
        widx_next     = widx_reg;
        finish_next   = finish_reg;
        started_next  = started_reg;
        len_done_next = len_done_reg;
        first_next    = first_reg;
        second_next   = second_reg;

        ctrl            = '0;
        ctrl.pad_ptr    = ptr_reg;
        ctrl.round_idx  = round_reg;
        ctrl.word_idx   = widx_reg;
        ctrl.pad_first  = first_reg;
        ctrl.pad_len    = !stat.pend_high || second_reg;

        case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (stat.in_accept)
                begin
                    // A full block is compressed before any padding.
                    if (stat.block_full)
                    begin
                        state_next    = ST_LOAD;
                        finish_next   = stat.in_last;
                        started_next  = 1'b0;
                        len_done_next = 1'b0;
                    end
                    else if (stat.in_last)
                    begin
                        state_next    = ST_PAD;
                        ptr_next      = stat.start_ptr;
                        finish_next   = 1'b1;
                        started_next  = 1'b1;
                        len_done_next = 1'b0;
                        first_next    = 1'b1;
                        second_next   = 1'b0;
                    end
                end
            end

            ST_PAD:
            begin
                // Write one padding word per cycle up to the end of the block.
                ctrl.pad_write = 1'b1;
                first_next     = 1'b0;
                if (ptr_reg == LAST_WORD)
                begin
                    state_next    = ST_LOAD;
                    len_done_next = ctrl.pad_len;
                end
                else
                begin
                    ptr_next = ptr_reg + 4'd1;
                end
            end

            ST_LOAD:
            begin
                ctrl.load_vars = 1'b1;
                ctrl.rd_addr   = md5_msg_index('0);
                round_next     = '0;
                state_next     = ST_ROUND;
            end

            ST_ROUND:
            begin
                // Fetch the message word of the following round.
                ctrl.round_en = 1'b1;
                ctrl.rd_addr  = md5_msg_index(round_plus);
                round_next    = round_plus;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                ctrl.add_chain = 1'b1;
                if (!finish_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!started_reg)
                begin
                    state_next   = ST_PAD;
                    ptr_next     = stat.start_ptr;
                    started_next = 1'b1;
                    first_next   = 1'b1;
                    second_next  = 1'b0;
                end
                else if (len_done_reg)
                begin
                    state_next = ST_DIGEST;
                    widx_next  = '0;
                end
                else
                begin
                    // Extra block that holds only the length.
                    state_next  = ST_PAD;
                    ptr_next    = '0;
                    first_next  = 1'b0;
                    second_next = 1'b1;
                end
            end

            ST_DIGEST:
            begin
                ctrl.out_valid = 1'b1;
                if (stat.out_accept)
                begin
                    widx_next = widx_reg + 2'd1;
                    if (widx_reg == LAST_DIGEST)
                    begin
                        ctrl.chain_init = 1'b1;
                        state_next      = ST_IDLE;
                        finish_next     = 1'b0;
                        started_next    = 1'b0;
                        len_done_next   = 1'b0;
                        second_next     = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/md5_stream_hasher.sv =====
// MD5 stream hasher, top level: an iterative MD5 engine over a byte stream.
// Each accepted request takes at most one message byte; a byte that
// completes a 64-byte block starts a compression (a load, 64 rounds through
// the single shared round unit, a chaining add), during which no request
// is accepted. An end-of-message request adds up to 16 padding word writes
// into the block buffer RAM and one compression, or two padding passes and
// two compressions when 56 or more bytes are pending, and then the digest
// leaves as four 32-bit words, one per cycle while the output is ready. The
// block buffer is written before it is read within each message and needs
// no clearing after reset.
// Depends on md5sh_pkg, md5sh_ram, md5sh_round and md5sh_ctrl.
module md5_stream_hasher
    import md5sh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // last_word
);

    md5sh_ctrl_t ctrl;
    md5sh_stat_t stat;

    logic [63:0] count_reg;
    logic [63:0] count_inc;
    logic [31:0] word_reg;
    logic [31:0] chain_reg [4];
    logic [31:0] var_reg [4];
    logic [31:0] var_next [4];

    logic        in_accept;
    logic        byte_take;
    logic [4:0]  lane_sh;
    logic [31:0] lane_mask;
    logic [31:0] pad_word;
    logic        ram_wr_en;
    logic [3:0]  ram_wr_addr;
    logic [31:0] ram_wr_data;
    logic [31:0] msg_word;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign byte_take = in_accept && s_axis_tuser[0];
    assign count_inc = count_reg + 64'd1;

    // Status toward the sequencer.
    always_comb
    begin
        stat.in_accept  = in_accept;
        stat.in_last    = s_axis_tlast;
        stat.block_full = s_axis_tuser[0] && (count_reg[5:0] == 6'h3f);
        stat.start_ptr  = (in_accept && s_axis_tuser[0]) ? count_inc[5:2] : count_reg[5:2];
        stat.pend_high  = &count_reg[5:3];
        stat.out_accept = m_axis_tvalid && m_axis_tready;
    end

    md5sh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // Byte count and chaining value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            chain_reg[0] <= MD5_IV_A;
            chain_reg[1] <= MD5_IV_B;
            chain_reg[2] <= MD5_IV_C;
            chain_reg[3] <= MD5_IV_D;
        end
        else if (ctrl.chain_init)
        begin
            count_reg    <= '0;
            chain_reg[0] <= MD5_IV_A;
            chain_reg[1] <= MD5_IV_B;
            chain_reg[2] <= MD5_IV_C;
            chain_reg[3] <= MD5_IV_D;
        end
        else
        begin
            if (byte_take)
            begin
                count_reg <= count_inc;
            end
            if (ctrl.add_chain)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
                end
            end
        end
    end

    // Partial message word, bytes placed little-endian.
    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            word_reg[{count_reg[1:0], 3'b000} +: 8] <= s_axis_tdata;
        end
    end

    // Padding word: marker after the pending bytes, zeros, or the bit length.
    assign lane_sh   = {count_reg[1:0], 3'b000};
    assign lane_mask = (32'd1 << lane_sh) - 32'd1;

    always_comb
    begin
        if (ctrl.pad_first)
        begin
            pad_word = (word_reg & lane_mask) | (PAD_MARKER << lane_sh);
        end
        else if (ctrl.pad_len && (ctrl.pad_ptr == LEN_LO_WORD))
        begin
            pad_word = {count_reg[28:0], 3'b000};
        end
        else if (ctrl.pad_len && (ctrl.pad_ptr == LEN_HI_WORD))
        begin
            pad_word = count_reg[60:29];
        end
        else
        begin
            pad_word = '0;
        end
    end

    // Block buffer write: a completed word from intake or a padding word.
    always_comb
    begin
        if (ctrl.pad_write)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ctrl.pad_ptr;
            ram_wr_data = pad_word;
        end
        else
        begin
            ram_wr_en   = byte_take && (count_reg[1:0] == 2'd3);
            ram_wr_addr = count_reg[5:2];
            ram_wr_data = {s_axis_tdata, word_reg[23:0]};
        end
    end

    md5sh_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BLK_WORDS)
    ) u_block_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ctrl.rd_addr),
        .rd_data (msg_word)
    );

    md5sh_round u_round (
        .round_idx (ctrl.round_idx),
        .a_in      (var_reg[0]),
        .b_in      (var_reg[1]),
        .c_in      (var_reg[2]),
        .d_in      (var_reg[3]),
        .msg_word  (msg_word),
        .a_out     (var_next[0]),
        .b_out     (var_next[1]),
        .c_out     (var_next[2]),
        .d_out     (var_next[3])
    );

    // Working variables of the compression.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_vars)
        begin
            for (int i = 0; i < 4; i++)
            begin
                var_reg[i] <= chain_reg[i];
            end
        end
        else if (ctrl.round_en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                var_reg[i] <= var_next[i];
            end
        end
    end

    // Handshakes and digest output.
    assign s_axis_tready = ctrl.in_ready;
    assign m_axis_tvalid = ctrl.out_valid;
    assign m_axis_tdata  = chain_reg[ctrl.word_idx];
    assign m_axis_tuser  = ctrl.word_idx;
    assign m_axis_tlast  = (ctrl.word_idx == LAST_DIGEST);

endmodule

// ===== hw/rtl/md5sh_checker.sv =====
// Port-level checker of the MD5 stream hasher and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module md5sh_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    logic       in_take;
    logic       out_take;
    logic       out_mid;
    logic       out_end;
    logic       word3;
    logic [1:0] idx_inc;

    // Accepted requests on both sides and the position of the digest word.
    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign out_take = m_axis_tvalid && m_axis_tready;
    assign out_mid  = out_take && !m_axis_tlast;
    assign out_end  = out_take && m_axis_tlast;
    assign word3    = (m_axis_tuser == 2'd3);
    assign idx_inc  = m_axis_tuser + 2'd1;

    // Intake and digest output are never open together.
    `ASSERT_NEVER(a_no_overlap, clk, rst_n, s_axis_tready && m_axis_tvalid, "intake open")

    // The last flag marks word three only.
    `ASSERT_CLK(a_last_idx, clk, rst_n, m_axis_tvalid |-> (m_axis_tlast == word3), "last flag")

    // Digest words follow in order.
    `ASSERT_CLK(a_idx_step, clk, rst_n,
                out_mid |=> m_axis_tvalid && m_axis_tuser == $past(idx_inc), "word skipped")

    // After the last digest word the block takes requests again.
    `ASSERT_CLK(a_back_idle, clk, rst_n, out_end |=> s_axis_tready && !m_axis_tvalid, "no intake")

    // An end-of-message request closes the intake for compression or padding.
    `ASSERT_CLK(a_end_busy, clk, rst_n, in_take && s_axis_tlast |=> !s_axis_tready, "still open")

endmodule

bind md5_stream_hasher md5sh_checker u_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the MD5 stream hasher: drives byte requests on
// the input stream, predicts each digest and checks the output stream.
// Depends on the md5_stream_hasher RTL only; it needs no package types.
module tb_top;

    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned RANDOM_ITEMS = 144;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned DRAIN_CYCLES = 200;

    // Initial chaining value of MD5.
    localparam logic [31:0] INIT_A = 32'h6745_2301;
    localparam logic [31:0] INIT_B = 32'hefcd_ab89;
    localparam logic [31:0] INIT_C = 32'h98ba_dcfe;
    localparam logic [31:0] INIT_D = 32'h1032_5476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // Additive constants of the 64 rounds.
    localparam logic [31:0] MD5_ADD_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, four per group of sixteen rounds.
    localparam int ROTATE_BY [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // One digest word as it leaves the output stream.
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        final_word;
    } digest_word_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] data_byte
    logic [0:0]  s_axis_tuser = 1'b0;   // [0] byte_valid
    logic        s_axis_tlast = 1'b0;   // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] digest_word
    logic [1:0]  m_axis_tuser;          // [1:0] word_index
    logic        m_axis_tlast;          // last_word

    // Digest model state.
    logic [31:0] chain_word [4];
    logic [7:0]  block_bytes [64];
    logic [63:0] message_bytes;

    digest_word_t digest_words_due [$];
    int unsigned  fail_count = 0;
    int unsigned  requests_sent = 0;
    bit           sender_burst = 1'b0;

    md5_stream_hasher u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_cycles();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rotate_left(input logic [31:0] x, input int amount);
        return (x << amount) | (x >> (32 - amount));
    endfunction

    // Start a new message from the initial chaining value.
    task automatic restart_digest();
        chain_word[0] = INIT_A;
        chain_word[1] = INIT_B;
        chain_word[2] = INIT_C;
        chain_word[3] = INIT_D;
        message_bytes = 64'd0;
    endtask

    // Run the 64 rounds over the block buffer and fold into the chain.
    task automatic compress_block();
        logic [31:0] msg_word [16];
        logic [31:0] a, b, c, d, f;
        int          g;
        for (int i = 0; i < 16; i++)
            msg_word[i] = {block_bytes[4 * i + 3], block_bytes[4 * i + 2],
                           block_bytes[4 * i + 1], block_bytes[4 * i]};
        a = chain_word[0];
        b = chain_word[1];
        c = chain_word[2];
        d = chain_word[3];
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0:
                begin
                    f = d ^ (b & (c ^ d));
                    g = i % 16;
                end
                1:
                begin
                    f = c ^ (d & (b ^ c));
                    g = (5 * i + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            f = a + f + MD5_ADD_K[i] + msg_word[g];
            a = d;
            d = c;
            c = b;
            b = b + rotate_left(f, ROTATE_BY[(i / 16) * 4 + i % 4]);
        end
        chain_word[0] = chain_word[0] + a;
        chain_word[1] = chain_word[1] + b;
        chain_word[2] = chain_word[2] + c;
        chain_word[3] = chain_word[3] + d;
    endtask

    // Absorb one accepted request; at the end of a message pad, finish and
    // queue the four digest words.
    task automatic absorb_request(input logic [7:0] data, input logic has_byte,
                                  input logic is_last);
        int           pend;
        logic [63:0]  bit_length;
        digest_word_t entry;
        if (has_byte)
        begin
            block_bytes[message_bytes[5:0]] = data;
            message_bytes = message_bytes + 64'd1;
            if (message_bytes[5:0] == 6'd0)
                compress_block();
        end
        if (is_last)
        begin
            pend = int'(message_bytes[5:0]);
            block_bytes[pend] = PAD_BYTE;
            for (int i = pend + 1; i < 64; i++)
                block_bytes[i] = 8'h00;
            // No room left for the length: it goes into an extra block.
            if (pend >= 56)
            begin
                compress_block();
                for (int i = 0; i < 64; i++)
                    block_bytes[i] = 8'h00;
            end
            bit_length = message_bytes << 3;
            for (int i = 0; i < 8; i++)
                block_bytes[56 + i] = bit_length[8 * i +: 8];
            compress_block();
            for (int k = 0; k < 4; k++)
            begin
                entry.word = chain_word[k];
                entry.index = k[1:0];
                entry.final_word = (k == 3);
                digest_words_due.push_back(entry);
            end
            restart_digest();
        end
    endtask

    // Send one request and wait for its handshake.
    task automatic send_request(input logic [7:0] data, input logic has_byte,
                                input logic is_last);
        int unsigned gap;
        gap = sender_burst ? 0 : idle_cycles();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= has_byte;
        s_axis_tlast <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        absorb_request(data, has_byte, is_last);
        requests_sent++;
    endtask

    // Send a message of random bytes with a few ignored requests mixed in.
    // The end marker rides on the last byte or comes as a request of its own.
    task automatic send_message(input int unsigned length, input bit last_on_byte);
        for (int unsigned i = 0; i < length; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_request(8'($urandom_range(0, 255)), 1'b1,
                         last_on_byte && (i == length - 1));
        end
        if (!last_on_byte || length == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // The digest of the empty message, ended by a request without a byte.
    task automatic test_empty_message();
        send_request(8'h5a, 1'b0, 1'b1);
    endtask

    // One-byte messages with the extreme byte values.
    task automatic test_byte_extremes();
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hff, 1'b1, 1'b1);
    endtask

    // Requests without a byte are ignored and leave the count alone.
    task automatic test_ignored_requests();
        send_request(8'ha5, 1'b0, 1'b0);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'h63, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
    endtask

    // A walking one across the byte, in one message.
    task automatic test_walking_bits();
        for (int i = 0; i < 8; i++)
            send_request(8'h01 << i, 1'b1, i == 7);
    endtask

    // Random messages: mostly short, many near the padding boundaries,
    // some spanning two blocks; back-to-back bursts now and then. The last
    // message is cut short so that the request total stays near the budget.
    task automatic test_random_messages();
        int unsigned start_count;
        int unsigned remaining;
        int unsigned roll;
        int unsigned length;
        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                length = $urandom_range(0, 12);
            else if (roll < 75)
                length = $urandom_range(52, 66);
            else if (roll < 90)
                length = $urandom_range(118, 130);
            else
                length = $urandom_range(13, 51);
            remaining = RANDOM_ITEMS - (requests_sent - start_count);
            if (length > remaining)
                length = remaining;
            sender_burst = ($urandom_range(0, 3) == 0);
            send_message(length, 1'($urandom_range(0, 1)));
        end
        sender_burst = 1'b0;
    endtask

    // Output ready: long open stretches sometimes, otherwise random stalls.
    initial
    begin : ready_driver
        int unsigned hold;
        @(posedge clk);
        forever
        begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
            m_axis_tready <= 1'b1;
            repeat (hold) @(posedge clk);
            hold = idle_cycles();
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // Check each accepted digest word against the oldest one due.
    always @(posedge clk)
    begin : digest_checker
        digest_word_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_words_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("Unexpected digest word: word=%h index=%0d last=%b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                due = digest_words_due.pop_front();
                if (m_axis_tdata !== due.word || m_axis_tuser !== due.index
                    || m_axis_tlast !== due.final_word)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("Digest mismatch: expected word=%h index=%0d last=%b,",
                                 due.word, due.index, due.final_word,
                                 " got word=%h index=%0d last=%b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Test sequence.
    initial
    begin
        restart_digest();
        for (int i = 0; i < 64; i++)
            block_bytes[i] = 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_message();
        test_byte_extremes();
        test_ignored_requests();
        test_walking_bits();
        test_random_messages();

        s_axis_tvalid <= 1'b0;
        while (digest_words_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (digest_words_due.size() > 0)
        begin
            fail_count++;
            $display("Digest words never delivered: %0d", digest_words_due.size());
        end
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/md5sh_pkg.sv
hw/rtl/md5sh_ram.sv
hw/rtl/md5sh_round.sv
hw/rtl/md5sh_ctrl.sv
hw/rtl/md5_stream_hasher.sv
hw/rtl/md5sh_checker.sv
bench/tb_top.sv
